[src/nearest_template_l1_match_defines.svh]
`ifndef NEAREST_TEMPLATE_L1_MATCH_DEFINES_SVH
`define NEAREST_TEMPLATE_L1_MATCH_DEFINES_SVH

// same-cycle implication
`define NTM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ntm check failed");

// next-cycle implication
`define NTM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ntm check failed");

`endif

[src/ntm_pkg.sv]
package ntm_pkg;

   localparam int LIB_DEPTH_DEF   = 256;
   localparam int GRID_BLOCKS_DEF = 64;
   localparam int DIM_BITS_DEF    = 12;

   localparam int CHAN_MAX     = 15;
   localparam int CHANNELS     = 3;
   localparam int DIST_CAP     = 4095;
   localparam int DIST_W       = 12;
   localparam int NIB_W        = 4;
   localparam int PIX_W        = 12;
   localparam int DIM_PORT_W   = 12;
   localparam int ENT_W        = 8;
   localparam int BLK_W        = 6;
   localparam int CSR_ENT_W    = 9;
   localparam int CSR_W        = 12;

   localparam logic [CSR_W-1:0] DEFAULT_NEAR = 12'd120;

   localparam logic [1:0] CMD_LOAD_BLOCK = 2'd0;
   localparam logic [1:0] CMD_LOAD_DIMS  = 2'd1;
   localparam logic [1:0] CMD_QUERY      = 2'd2;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_EXACT = 2'd1;
   localparam logic [1:0] KIND_NEAR  = 2'd2;

   localparam logic CSR_ENTRIES   = 1'b0;
   localparam logic CSR_THRESHOLD = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD_BLK,
      ST_LOAD_DIM,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic blk_we;
      logic dim_we;
      logic rd_en;
   } lib_ctl_type;

   typedef struct packed {
      logic valid;
      logic searched;
      logic gated;
   } cand_ctl_type;

   function automatic logic [NIB_W-1:0] absdiff(input logic [NIB_W-1:0] a,
                                                input logic [NIB_W-1:0] b);
      absdiff = (a > b) ? a - b : b - a;
   endfunction

endpackage

[src/nearest_template_l1_match.sv]
// Template matcher with a library of LIB_DEPTH signatures of GRID_BLOCKS
// three-nibble blocks plus crop dimensions. A word is taken when start is
// high and busy is low. Load words write their entry and return to idle;
// ignored words (command 3, block index out of range, load to an entry beyond the
// library) never raise busy. In each query word's pass, the running
// distance memory is read, updated and written back for one library entry
// per cycle, and the best-match search rides along in the same pass. After
// the last grid block of a query, one result is strobed on rsp_strobe for a
// single cycle, in the cycle busy falls; it cannot be held off, so the
// receiver must take it then. Results appear in no other case.
module nearest_template_l1_match #(
   parameter int LIB_DEPTH   = ntm_pkg::LIB_DEPTH_DEF,
   parameter int GRID_BLOCKS = ntm_pkg::GRID_BLOCKS_DEF,
   parameter int DIM_BITS    = ntm_pkg::DIM_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_command,
   input  logic [ntm_pkg::ENT_W-1:0]     req_entry,
   input  logic [ntm_pkg::BLK_W-1:0]     req_block,
   input  logic [ntm_pkg::NIB_W-1:0]     req_red,
   input  logic [ntm_pkg::NIB_W-1:0]     req_green,
   input  logic [ntm_pkg::NIB_W-1:0]     req_blue,
   input  logic [ntm_pkg::DIM_PORT_W-1:0] req_width,
   input  logic [ntm_pkg::DIM_PORT_W-1:0] req_height,
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_match_kind,
   output logic [ntm_pkg::ENT_W-1:0]     rsp_matched_entry,
   output logic [ntm_pkg::DIST_W-1:0]    rsp_distance,
   input  logic                          csr_write_en,
   input  logic                          csr_index,
   input  logic [ntm_pkg::CSR_W-1:0]     csr_wdata
);
   import ntm_pkg::*;

   localparam int IW       = (LIB_DEPTH > 1) ? $clog2(LIB_DEPTH) : 1;
   localparam int AW       = (LIB_DEPTH * GRID_BLOCKS > 1)
                             ? $clog2(LIB_DEPTH * GRID_BLOCKS) : 1;
   localparam int DW       = (DIM_BITS < DIM_PORT_W) ? DIM_BITS : DIM_PORT_W;
   localparam int CmpW     = ((IW > CSR_ENT_W) ? IW : CSR_ENT_W) + 1;
   localparam int FullDist = GRID_BLOCKS * CHANNELS * CHAN_MAX;
   localparam int NoneDist = (FullDist + 1 > DIST_CAP) ? DIST_CAP : FullDist + 1;

   state_type state_ff, state_in;

   logic [CSR_ENT_W-1:0] entries_ff;
   logic [CSR_W-1:0]     thr_ff;

   logic [1:0]       cmd_ff;
   logic [ENT_W-1:0] ent_ff;
   logic [BLK_W-1:0] blk_ff;
   logic [NIB_W-1:0] red_ff, green_ff, blue_ff;
   logic [DW-1:0]    qw_ff, qh_ff;

   logic          fresh_ff;
   logic [IW-1:0] idx_ff;
   logic [AW-1:0] addr_ff;
   logic          v1_ff;
   logic [IW-1:0] idx1_ff;

   logic          take_in;
   logic          blk_ok, ent_ok, last_blk, idx_last;
   lib_ctl_type   lib_ctl;
   cand_ctl_type  cand_ctl;

   logic [AW-1:0]     blk_waddr;
   logic [PIX_W-1:0]  lib_pix;
   logic [2*DW-1:0]   lib_dims;
   logic [DW-1:0]     lib_w, lib_h;
   logic [DIST_W-1:0] new_dist;

   logic              exact_found, near_found;
   logic [IW-1:0]     exact_idx, near_idx;
   logic [DIST_W-1:0] near_best;

   logic              rsp_strobe_ff;
   logic [1:0]        rsp_kind_ff, kind_in;
   logic [ENT_W-1:0]  rsp_entry_ff, entry_in;
   logic [DIST_W-1:0] rsp_dist_ff, dist_in;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= '0;
         thr_ff     <= DEFAULT_NEAR;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_ENTRIES:   entries_ff <= csr_wdata[CSR_ENT_W-1:0];
            CSR_THRESHOLD: thr_ff     <= csr_wdata;
            default:       thr_ff     <= thr_ff;
         endcase
      end
   end

   assign take_in  = start && (state_ff == ST_IDLE);
   assign blk_ok   = 9'(req_block) < 9'(GRID_BLOCKS);
   assign ent_ok   = 13'(req_entry) < 13'(LIB_DEPTH);
   assign last_blk = 9'(blk_ff) == 9'(GRID_BLOCKS - 1);
   assign idx_last = idx_ff == IW'(LIB_DEPTH - 1);

   always_ff @(posedge clock) begin
      if (take_in) begin
         cmd_ff   <= req_command;
         ent_ff   <= req_entry;
         blk_ff   <= req_block;
         red_ff   <= req_red;
         green_ff <= req_green;
         blue_ff  <= req_blue;
         qw_ff    <= req_width[DW-1:0];
         qh_ff    <= req_height[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      lib_ctl  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start && blk_ok) begin
               case (req_command)
                  CMD_LOAD_BLOCK: if (ent_ok) state_in = ST_LOAD_BLK;
                  CMD_LOAD_DIMS:  if (ent_ok) state_in = ST_LOAD_DIM;
                  CMD_QUERY:      state_in = ST_RUN;
                  default:        state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD_BLK: begin
            lib_ctl.blk_we = 1'b1;
            state_in = ST_IDLE;
         end
         ST_LOAD_DIM: begin
            lib_ctl.dim_we = 1'b1;
            state_in = ST_IDLE;
         end
         ST_RUN: begin
            lib_ctl.rd_en = 1'b1;
            if (idx_last) state_in = ST_DRAIN;
         end
         ST_DRAIN:  state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   assign busy = state_ff != ST_IDLE;

   // pass sequencer and read pipeline
   always_ff @(posedge clock) begin
      if (take_in) begin
         idx_ff  <= '0;
         addr_ff <= AW'(req_block);
      end else if (lib_ctl.rd_en) begin
         idx_ff  <= idx_ff + 1'b1;
         addr_ff <= addr_ff + AW'(GRID_BLOCKS);
      end
      idx1_ff <= idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         fresh_ff <= 1'b1;
      end else begin
         v1_ff <= lib_ctl.rd_en;
         // distance memory holds real data after the first full pass
         if (state_ff == ST_FINISH) fresh_ff <= 1'b0;
      end
   end

   assign blk_waddr = AW'(AW'(ent_ff) * AW'(GRID_BLOCKS) + AW'(blk_ff));

   ntm_lib_store #(
      .LIB_DEPTH   (LIB_DEPTH),
      .GRID_BLOCKS (GRID_BLOCKS),
      .DW          (DW),
      .IW          (IW),
      .AW          (AW)
   ) u_lib_store (
      .clock     (clock),
      .ctl       (lib_ctl),
      .blk_waddr (blk_waddr),
      .blk_wdata ({red_ff, green_ff, blue_ff}),
      .dim_waddr (IW'(ent_ff)),
      .dim_wdata ({qw_ff, qh_ff}),
      .blk_raddr (addr_ff),
      .dim_raddr (idx_ff),
      .blk_rdata (lib_pix),
      .dim_rdata (lib_dims)
   );

   ntm_dist_unit #(
      .LIB_DEPTH (LIB_DEPTH),
      .IW        (IW)
   ) u_dist_unit (
      .clock     (clock),
      .rd_en     (lib_ctl.rd_en),
      .rd_idx    (idx_ff),
      .wr_en     (v1_ff),
      .wr_idx    (idx1_ff),
      .clear_old (fresh_ff || (blk_ff == '0)),
      .red       (red_ff),
      .green     (green_ff),
      .blue      (blue_ff),
      .lib_pix   (lib_pix),
      .new_dist  (new_dist)
   );

   assign lib_w = lib_dims[2*DW-1:DW];
   assign lib_h = lib_dims[DW-1:0];

   always_comb begin
      cand_ctl.valid    = v1_ff;
      cand_ctl.searched = CmpW'(idx1_ff) < CmpW'(entries_ff);
      cand_ctl.gated    = (lib_w != '0) && (lib_h != '0)
                          && (lib_w == qw_ff) && (lib_h == qh_ff);
   end

   ntm_best_track #(
      .IW (IW)
   ) u_best_track (
      .clock       (clock),
      .reset       (reset),
      .clear       (take_in),
      .ctl         (cand_ctl),
      .idx         (idx1_ff),
      .cand_dist   (new_dist),
      .exact_found (exact_found),
      .exact_idx   (exact_idx),
      .near_found  (near_found),
      .near_idx    (near_idx),
      .near_best   (near_best)
   );

   always_comb begin
      kind_in  = KIND_NONE;
      entry_in = '0;
      dist_in  = DIST_W'(NoneDist);
      if (exact_found) begin
         kind_in  = KIND_EXACT;
         entry_in = ENT_W'(exact_idx);
         dist_in  = '0;
      end else if (near_found) begin
         dist_in = near_best;
         if (near_best <= thr_ff) begin
            kind_in  = KIND_NEAR;
            entry_in = ENT_W'(near_idx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (state_ff == ST_FINISH) && last_blk;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FINISH) begin
         rsp_kind_ff  <= kind_in;
         rsp_entry_ff <= entry_in;
         rsp_dist_ff  <= dist_in;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_match_kind    = rsp_kind_ff;
   assign rsp_matched_entry = rsp_entry_ff;
   assign rsp_distance      = rsp_dist_ff;

endmodule

[src/ntm_lib_store.sv]
module ntm_lib_store #(
   parameter int LIB_DEPTH   = ntm_pkg::LIB_DEPTH_DEF,
   parameter int GRID_BLOCKS = ntm_pkg::GRID_BLOCKS_DEF,
   parameter int DW          = ntm_pkg::DIM_BITS_DEF,
   parameter int IW          = 8,
   parameter int AW          = 14
) (
   input  logic                    clock,
   input  ntm_pkg::lib_ctl_type    ctl,
   input  logic [AW-1:0]           blk_waddr,
   input  logic [ntm_pkg::PIX_W-1:0] blk_wdata,
   input  logic [IW-1:0]           dim_waddr,
   input  logic [2*DW-1:0]         dim_wdata,
   input  logic [AW-1:0]           blk_raddr,
   input  logic [IW-1:0]           dim_raddr,
   output logic [ntm_pkg::PIX_W-1:0] blk_rdata,
   output logic [2*DW-1:0]         dim_rdata
);
   import ntm_pkg::*;

   logic [PIX_W-1:0] blk_mem [LIB_DEPTH*GRID_BLOCKS];
   logic [2*DW-1:0]  dim_mem [LIB_DEPTH];
   logic [PIX_W-1:0] blk_rdata_ff;
   logic [2*DW-1:0]  dim_rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.blk_we) begin
         blk_mem[blk_waddr] <= blk_wdata;
      end
      if (ctl.rd_en) begin
         blk_rdata_ff <= blk_mem[blk_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.dim_we) begin
         dim_mem[dim_waddr] <= dim_wdata;
      end
      if (ctl.rd_en) begin
         dim_rdata_ff <= dim_mem[dim_raddr];
      end
   end

   assign blk_rdata = blk_rdata_ff;
   assign dim_rdata = dim_rdata_ff;

endmodule

[src/ntm_dist_unit.sv]
module ntm_dist_unit #(
   parameter int LIB_DEPTH = ntm_pkg::LIB_DEPTH_DEF,
   parameter int IW        = 8
) (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [IW-1:0]             rd_idx,
   input  logic                      wr_en,
   input  logic [IW-1:0]             wr_idx,
   input  logic                      clear_old,
   input  logic [ntm_pkg::NIB_W-1:0] red,
   input  logic [ntm_pkg::NIB_W-1:0] green,
   input  logic [ntm_pkg::NIB_W-1:0] blue,
   input  logic [ntm_pkg::PIX_W-1:0] lib_pix,
   output logic [ntm_pkg::DIST_W-1:0] new_dist
);
   import ntm_pkg::*;

   logic [DIST_W-1:0] dist_mem [LIB_DEPTH];
   logic [DIST_W-1:0] rd_data_ff;
   logic [DIST_W-1:0] old_dist;
   logic [DIST_W:0]   sum;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         dist_mem[wr_idx] <= new_dist;
      end
      if (rd_en) begin
         rd_data_ff <= dist_mem[rd_idx];
      end
   end

   always_comb begin
      old_dist = clear_old ? '0 : rd_data_ff;
      sum = (DIST_W+1)'(old_dist)
          + (DIST_W+1)'(absdiff(red,   lib_pix[11:8]))
          + (DIST_W+1)'(absdiff(green, lib_pix[7:4]))
          + (DIST_W+1)'(absdiff(blue,  lib_pix[3:0]));
      // saturate at the cap
      new_dist = sum[DIST_W] ? DIST_W'(DIST_CAP) : sum[DIST_W-1:0];
   end

endmodule

[src/ntm_best_track.sv]
module ntm_best_track #(
   parameter int IW = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  ntm_pkg::cand_ctl_type      ctl,
   input  logic [IW-1:0]              idx,
   input  logic [ntm_pkg::DIST_W-1:0] cand_dist,
   output logic                       exact_found,
   output logic [IW-1:0]              exact_idx,
   output logic                       near_found,
   output logic [IW-1:0]              near_idx,
   output logic [ntm_pkg::DIST_W-1:0] near_best
);
   import ntm_pkg::*;

   logic              exact_found_ff;
   logic              near_found_ff;
   logic [IW-1:0]     exact_idx_ff;
   logic [IW-1:0]     near_idx_ff;
   logic [DIST_W-1:0] near_best_ff;
   logic              take_exact;
   logic              take_near;

   always_comb begin
      take_exact = ctl.valid && ctl.searched && !exact_found_ff && (cand_dist == '0);
      // strict less keeps the lowest index on ties
      take_near  = ctl.valid && ctl.searched && ctl.gated
                   && (!near_found_ff || (cand_dist < near_best_ff));
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         exact_found_ff <= 1'b0;
         near_found_ff  <= 1'b0;
      end else begin
         if (take_exact) begin
            exact_found_ff <= 1'b1;
         end
         if (take_near) begin
            near_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_exact) begin
         exact_idx_ff <= idx;
      end
      if (take_near) begin
         near_idx_ff  <= idx;
         near_best_ff <= cand_dist;
      end
   end

   assign exact_found = exact_found_ff;
   assign exact_idx   = exact_idx_ff;
   assign near_found  = near_found_ff;
   assign near_idx    = near_idx_ff;
   assign near_best   = near_best_ff;

endmodule

[src/ntm_checker.sv]
`include "nearest_template_l1_match_defines.svh"

module ntm_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_strobe,
   input logic [1:0]                 rsp_match_kind,
   input logic [ntm_pkg::ENT_W-1:0]  rsp_matched_entry,
   input logic [ntm_pkg::DIST_W-1:0] rsp_distance
);
   import ntm_pkg::*;

   // a result needs a full pass, so strobes never touch
   `NTM_ASSERT_NEXT(a_strobe_gap, clock, reset, rsp_strobe, !rsp_strobe)

   `NTM_ASSERT_IMP(a_kind_legal, clock, reset, rsp_strobe, rsp_match_kind != 2'd3)

   `NTM_ASSERT_IMP(a_none_entry, clock, reset,
      rsp_strobe && (rsp_match_kind == KIND_NONE), rsp_matched_entry == '0)

   `NTM_ASSERT_IMP(a_exact_zero, clock, reset,
      rsp_strobe && (rsp_match_kind == KIND_EXACT), rsp_distance == '0)

   // a result only follows the end of a pass
   `NTM_ASSERT_IMP(a_strobe_idle, clock, reset, rsp_strobe, !busy || $past(start))

endmodule

bind nearest_template_l1_match ntm_checker u_ntm_checker (.*);

[verif/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ntm_pkg::*;

   localparam int CLK_PERIOD    = 8;
   localparam int RESET_CYCLES  = 9;
   localparam int LAST_BLOCK    = GRID_BLOCKS_DEF - 1;
   localparam int FULL_SPAN     = GRID_BLOCKS_DEF * CHANNELS * CHAN_MAX;
   localparam int NO_MATCH_DIST = (FULL_SPAN + 1 > DIST_CAP) ? DIST_CAP : FULL_SPAN + 1;
   localparam int SETTLE_CYCLES = LIB_DEPTH_DEF + 16;
   localparam int LIB_FILL      = 10;
   localparam int RANDOM_ITEMS  = 480;
   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int REPORT_LIMIT  = 10;

   localparam logic [1:0]  CMD_IGNORED = 2'd3;
   localparam logic [11:0] DIM_MAX     = 12'hFFF;

   localparam int STYLE_EXACT = 0;
   localparam int STYLE_NEAR  = 1;
   localparam int STYLE_NOISY = 2;

   typedef struct packed {
      logic [1:0]            command;
      logic [ENT_W-1:0]      entry;
      logic [BLK_W-1:0]      block;
      logic [NIB_W-1:0]      red;
      logic [NIB_W-1:0]      green;
      logic [NIB_W-1:0]      blue;
      logic [DIM_PORT_W-1:0] width;
      logic [DIM_PORT_W-1:0] height;
   } word_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ENT_W-1:0]  entry;
      logic [DIST_W-1:0] distance;
   } match_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [1:0]            req_command;
   logic [ENT_W-1:0]      req_entry;
   logic [BLK_W-1:0]      req_block;
   logic [NIB_W-1:0]      req_red;
   logic [NIB_W-1:0]      req_green;
   logic [NIB_W-1:0]      req_blue;
   logic [DIM_PORT_W-1:0] req_width;
   logic [DIM_PORT_W-1:0] req_height;
   logic                  rsp_strobe;
   logic [1:0]            rsp_match_kind;
   logic [ENT_W-1:0]      rsp_matched_entry;
   logic [DIST_W-1:0]     rsp_distance;
   logic                  csr_write_en;
   logic                  csr_index;
   logic [CSR_W-1:0]      csr_wdata;

   // shadow of the library, running distances and registers
   logic [PIX_W-1:0]      lib_blk [LIB_DEPTH_DEF][GRID_BLOCKS_DEF];
   logic [DIM_PORT_W-1:0] lib_w [LIB_DEPTH_DEF];
   logic [DIM_PORT_W-1:0] lib_h [LIB_DEPTH_DEF];
   int                    run_dist [LIB_DEPTH_DEF];
   int                    cfg_entries;
   int                    cfg_thresh;

   match_type pending_matches[$];
   match_type mon_got;
   match_type mon_want;

   bit req_held;
   bit gap_mode;
   int items_sent;
   int mismatches;
   int cycle_count;

   nearest_template_l1_match dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_entry         (req_entry),
      .req_block         (req_block),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .req_width         (req_width),
      .req_height        (req_height),
      .rsp_strobe        (rsp_strobe),
      .rsp_match_kind    (rsp_match_kind),
      .rsp_matched_entry (rsp_matched_entry),
      .rsp_distance      (rsp_distance),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic int chan_gap(input logic [NIB_W-1:0] a, input logic [NIB_W-1:0] b);
      return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
   endfunction

   // one accepted word: update the shadow state, queue a match on the last block
   task automatic l1_match_step(input word_type w);
      int        i, d, n, best, best_entry;
      bit        found;
      match_type m;
      case (w.command)
         CMD_LOAD_BLOCK: lib_blk[w.entry][w.block] = {w.red, w.green, w.blue};
         CMD_LOAD_DIMS: begin
            lib_w[w.entry] = w.width;
            lib_h[w.entry] = w.height;
         end
         CMD_QUERY: begin
            if (w.block == 0)
               for (i = 0; i < LIB_DEPTH_DEF; i++) run_dist[i] = 0;
            for (i = 0; i < LIB_DEPTH_DEF; i++) begin
               d = run_dist[i] + chan_gap(w.red, lib_blk[i][w.block][11:8])
                   + chan_gap(w.green, lib_blk[i][w.block][7:4])
                   + chan_gap(w.blue, lib_blk[i][w.block][3:0]);
               run_dist[i] = (d > DIST_CAP) ? DIST_CAP : d;
            end
            if (w.block == LAST_BLOCK) begin
               n = (cfg_entries > LIB_DEPTH_DEF) ? LIB_DEPTH_DEF : cfg_entries;
               m.kind = KIND_NONE;
               best_entry = 0;
               best = NO_MATCH_DIST;
               found = 1'b0;
               for (i = 0; i < n; i++) begin
                  if (m.kind == KIND_NONE && run_dist[i] == 0) begin
                     m.kind = KIND_EXACT;
                     best_entry = i;
                     best = 0;
                  end
               end
               if (m.kind == KIND_NONE) begin
                  for (i = 0; i < n; i++) begin
                     if (lib_w[i] != 0 && lib_h[i] != 0 && lib_w[i] == w.width &&
                         lib_h[i] == w.height && (!found || run_dist[i] < best)) begin
                        best = run_dist[i];
                        best_entry = i;
                        found = 1'b1;
                     end
                  end
                  if (found && best <= cfg_thresh)
                     m.kind = KIND_NEAR;
                  else
                     best_entry = 0;
               end
               m.entry = best_entry[ENT_W-1:0];
               m.distance = best[DIST_W-1:0];
               pending_matches.push_back(m);
            end
         end
         default: ;
      endcase
   endtask

   task automatic note_mismatch(input bit orphan, input match_type want, input match_type got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         if (orphan)
            $display("unexpected result word: kind %0d entry %0d distance %0d",
                     got.kind, got.entry, got.distance);
         else
            $display("mismatch: expected kind %0d entry %0d distance %0d, got %0d %0d %0d",
                     want.kind, want.entry, want.distance, got.kind, got.entry, got.distance);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe !== 1'b0) begin
         mon_got = {rsp_match_kind, rsp_matched_entry, rsp_distance};
         if (pending_matches.size() == 0) begin
            note_mismatch(1'b1, mon_got, mon_got);
         end else begin
            mon_want = pending_matches.pop_front();
            if (mon_got.kind !== mon_want.kind || mon_got.entry !== mon_want.entry ||
                mon_got.distance !== mon_want.distance)
               note_mismatch(1'b0, mon_want, mon_got);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gap_mode || r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   function automatic word_type word_of(input logic [1:0] cmd, input int ent, input int blk,
                                        input logic [11:0] rgb, input logic [11:0] w,
                                        input logic [11:0] h);
      word_type x;
      x.command = cmd;
      x.entry = ent[ENT_W-1:0];
      x.block = blk[BLK_W-1:0];
      {x.red, x.green, x.blue} = rgb;
      x.width = w;
      x.height = h;
      return x;
   endfunction

   function automatic logic [23:0] pick_dims();
      case ($urandom_range(0, 9))
         0: return {12'd640, 12'd480};
         1: return {12'd320, 12'd240};
         2: return {12'd1, 12'd1};
         3, 4, 5: return {12'd4094, 12'd2048};
         6: return {12'd0, 12'($urandom_range(0, 4095))};
         7: return {12'($urandom_range(0, 4095)), 12'd0};
         default: return {12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095))};
      endcase
   endfunction

   task automatic send_word(input word_type w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_command <= w.command;
      req_entry <= w.entry;
      req_block <= w.block;
      req_red <= w.red;
      req_green <= w.green;
      req_blue <= w.blue;
      req_width <= w.width;
      req_height <= w.height;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      req_held = 1'b1;
      if (w.command != CMD_IGNORED) items_sent++;
      l1_match_step(w);
   endtask

   task automatic release_req();
      if (req_held) begin
         start <= 1'b0;
         req_held = 1'b0;
         @(posedge clock);
      end
   endtask

   // block may still be grinding on a query word that yields nothing
   task automatic settle();
      release_req();
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [CSR_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_ENTRIES)
         cfg_entries = val[CSR_ENT_W-1:0];
      else
         cfg_thresh = val;
      @(posedge clock);
   endtask

   task automatic query_word(input int blk, input logic [11:0] rgb, input logic [11:0] w,
                             input logic [11:0] h);
      send_word(word_of(CMD_QUERY, $urandom_range(0, 255), blk, rgb, w, h));
   endtask

   task automatic load_block(input int ent, input int blk, input logic [11:0] rgb);
      send_word(word_of(CMD_LOAD_BLOCK, ent, blk, rgb, 12'($urandom_range(0, 4095)),
                        12'($urandom_range(0, 4095))));
   endtask

   task automatic load_dims(input int ent, input logic [11:0] w, input logic [11:0] h);
      send_word(word_of(CMD_LOAD_DIMS, ent, $urandom_range(0, LAST_BLOCK),
                        12'($urandom_range(0, 4095)), w, h));
   endtask

   function automatic logic [3:0] nudge(input logic [3:0] v);
      int x, step;
      step = $urandom_range(1, 3);
      if ($urandom_range(0, 1)) x = int'(v) + step;
      else x = int'(v) - step;
      if (x < 0) x = 0;
      if (x > CHAN_MAX) x = CHAN_MAX;
      return x[3:0];
   endfunction

   function automatic logic [11:0] shaped_block(input int t, input int blk, input int style);
      logic [11:0] v;
      int          c;
      v = lib_blk[t][blk];
      for (c = 0; c < CHANNELS; c++) begin
         if (style == STYLE_NOISY)
            v[c*4 +: 4] = 4'($urandom_range(0, 15));
         else if (style == STYLE_NEAR && $urandom_range(0, 7) == 0)
            v[c*4 +: 4] = nudge(v[c*4 +: 4]);
      end
      return v;
   endfunction

   task automatic stray_load();
      logic [23:0] dims;
      if ($urandom_range(0, 1)) begin
         load_block($urandom_range(1, 255), $urandom_range(0, LAST_BLOCK),
                    12'($urandom_range(0, 4095)));
      end else begin
         dims = pick_dims();
         load_dims($urandom_range(1, 255), dims[23:12], dims[11:0]);
      end
   endtask

   // only the filled entries are ever searched
   task automatic fill_library();
      int          i, k;
      logic [23:0] dims;
      gap_mode = 1'b0;
      for (i = 0; i < LIB_FILL; i++) begin
         for (k = 0; k <= LAST_BLOCK; k++)
            load_block(i, k, (i == 0) ? 12'h000 : 12'($urandom_range(0, 4095)));
         dims = pick_dims();
         // entry 0: all-zero signature, dims nobody else gets
         if (i == 0) load_dims(i, DIM_MAX, DIM_MAX);
         else load_dims(i, dims[23:12], dims[11:0]);
      end
   endtask

   task automatic test_ignored_commands();
      gap_mode = 1'b1;
      send_word(word_of(CMD_IGNORED, 255, LAST_BLOCK, 12'hFFF, DIM_MAX, DIM_MAX));
      send_word(word_of(CMD_IGNORED, 0, 0, 12'h000, 12'd0, 12'd0));
   endtask

   task automatic test_empty_search();
      query_word(0, 12'($urandom_range(0, 4095)), DIM_MAX, DIM_MAX);
      query_word(LAST_BLOCK, 12'($urandom_range(0, 4095)), DIM_MAX, DIM_MAX);
      settle();
      write_csr(CSR_ENTRIES, 12'(LIB_FILL));
   endtask

   task automatic test_exact_match();
      query_word(0, lib_blk[7][0], 12'd33, 12'd0);
      query_word(LAST_BLOCK, lib_blk[7][LAST_BLOCK], 12'd33, 12'd0);
      // duplicate signature: lower index wins
      load_block(9, 0, 12'h5A3);
      load_block(9, LAST_BLOCK, 12'h3C6);
      load_block(3, 0, 12'h5A3);
      load_block(3, LAST_BLOCK, 12'h3C6);
      query_word(0, 12'h5A3, 12'd640, 12'd480);
      query_word(LAST_BLOCK, 12'h3C6, 12'd640, 12'd480);
   endtask

   task automatic near_probe();
      query_word(0, 12'h100, DIM_MAX, DIM_MAX);
      query_word(LAST_BLOCK, 12'h002, DIM_MAX, DIM_MAX);
   endtask

   task automatic test_near_threshold();
      near_probe();
      settle();
      write_csr(CSR_THRESHOLD, 12'd0);
      near_probe();
      settle();
      write_csr(CSR_THRESHOLD, 12'hFFF);
      near_probe();
   endtask

   task automatic test_dimension_gating();
      load_dims(5, 12'd0, 12'd77);
      query_word(0, 12'($urandom_range(0, 4095)), 12'd0, 12'd77);
      query_word(LAST_BLOCK, 12'($urandom_range(0, 4095)), 12'd0, 12'd77);
   endtask

   task automatic test_out_of_order_query();
      query_word(LAST_BLOCK, 12'h000, DIM_MAX, DIM_MAX);
      query_word(20, 12'hF0F, 12'd1, 12'd1);
      query_word(20, 12'hF0F, 12'd1, 12'd1);
      query_word(LAST_BLOCK, 12'h000, DIM_MAX, DIM_MAX);
   endtask

   // all-15 query against the all-zero entry, no clear: running sum pins at the cap
   task automatic test_distance_saturation();
      settle();
      write_csr(CSR_ENTRIES, 12'(LIB_FILL));
      write_csr(CSR_THRESHOLD, 12'hFFF);
      repeat (96) query_word($urandom_range(1, LAST_BLOCK - 1), 12'hFFF,
                             12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
      query_word(LAST_BLOCK, 12'hFFF, DIM_MAX, DIM_MAX);
   endtask

   task automatic query_sequence(input bit in_order);
      int          n_eff, t, style, len, k;
      logic [23:0] dims;
      n_eff = (cfg_entries > LIB_FILL) ? LIB_FILL : cfg_entries;
      if (n_eff > 0 && $urandom_range(0, 4) != 0) t = $urandom_range(0, n_eff - 1);
      else t = $urandom_range(0, LIB_FILL - 1);
      k = $urandom_range(0, 9);
      style = (k < 3) ? STYLE_EXACT : (k < 8) ? STYLE_NEAR : STYLE_NOISY;
      if ($urandom_range(0, 3) != 0) dims = {lib_w[t], lib_h[t]};
      else dims = pick_dims();
      if (in_order) begin
         for (k = 0; k <= LAST_BLOCK; k++)
            query_word(k, shaped_block(t, k, style), dims[23:12], dims[11:0]);
      end else begin
         len = $urandom_range(0, 10);
         if ($urandom_range(0, 1))
            query_word(0, shaped_block(t, 0, style), dims[23:12], dims[11:0]);
         repeat (len) begin
            if ($urandom_range(0, 9) == 0) stray_load();
            k = $urandom_range(0, LAST_BLOCK - 1);
            query_word(k, shaped_block(t, k, style), 12'($urandom_range(0, 4095)),
                       12'($urandom_range(0, 4095)));
         end
         query_word(LAST_BLOCK, shaped_block(t, LAST_BLOCK, style), dims[23:12], dims[11:0]);
      end
   endtask

   task automatic library_updates();
      int s, d, k;
      if ($urandom_range(0, 9) == 0) begin
         s = $urandom_range(0, LIB_FILL - 1);
         d = $urandom_range(1, LIB_FILL - 1);
         for (k = 0; k <= LAST_BLOCK; k++) load_block(d, k, lib_blk[s][k]);
         load_dims(d, lib_w[s], lib_h[s]);
      end else begin
         repeat ($urandom_range(1, 6)) stray_load();
      end
   endtask

   task automatic retune_registers();
      logic [CSR_W-1:0] n, th;
      case ($urandom_range(0, 9))
         0: n = 12'd0;
         1: n = 12'd1;
         2: n = 12'(LIB_FILL);
         // bits above the register are dropped
         3: n = 12'h200 | 12'($urandom_range(0, LIB_FILL));
         default: n = 12'($urandom_range(1, LIB_FILL));
      endcase
      case ($urandom_range(0, 7))
         0: th = 12'd0;
         1: th = 12'd2880;
         2: th = 12'hFFF;
         3: th = 12'($urandom_range(0, 4095));
         default: th = 12'($urandom_range(0, 400));
      endcase
      settle();
      write_csr(CSR_ENTRIES, n);
      write_csr(CSR_THRESHOLD, th);
   endtask

   task automatic test_random_traffic();
      int first_item, scen, pick;
      first_item = items_sent;
      scen = 0;
      while (items_sent - first_item < RANDOM_ITEMS) begin
         if (scen % 6 == 5) retune_registers();
         gap_mode = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 40)
            query_sequence(1'b1);
         else if (pick < 70)
            query_sequence(1'b0);
         else if (pick < 90)
            library_updates();
         else
            repeat ($urandom_range(1, 3))
               send_word(word_of(CMD_IGNORED, $urandom_range(0, 255),
                                 $urandom_range(0, LAST_BLOCK), 12'($urandom_range(0, 4095)),
                                 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095))));
         scen++;
      end
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_command <= CMD_LOAD_BLOCK;
      req_entry <= '0;
      req_block <= '0;
      req_red <= '0;
      req_green <= '0;
      req_blue <= '0;
      req_width <= '0;
      req_height <= '0;
      csr_write_en <= 1'b0;
      csr_index <= CSR_ENTRIES;
      csr_wdata <= '0;
      for (int i = 0; i < LIB_DEPTH_DEF; i++) run_dist[i] = 0;
      cfg_entries = 0;
      cfg_thresh = DEFAULT_NEAR;
      req_held = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      fill_library();
      test_ignored_commands();
      test_empty_search();
      test_exact_match();
      test_near_threshold();
      test_dimension_gating();
      test_out_of_order_query();
      test_distance_saturation();
      test_random_traffic();
      settle();

      if (mismatches == 0 && pending_matches.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
